FILE: hw/rtl/mmi_pkg.sv
`timescale 1ns / 1ps

package mmi_pkg;

  localparam int ElemW   = 8;
  localparam int DimN    = 3;
  localparam int OddCnt  = 1 << (ElemW - 1);

  typedef logic [ElemW-1:0] elem_t;
  typedef elem_t [DimN-1:0][DimN-1:0] mat_t;
  typedef elem_t [DimN-1:0] vec_t;

  // what the merge stage hands to the scaling lanes
  typedef struct packed {
    logic  odd;
    elem_t dinv;
  } det_info_t;

  typedef elem_t [OddCnt-1:0] inv_tbl_t;

  // inverse of every odd byte mod 256, newton steps run at elaboration
  function automatic inv_tbl_t build_inv_tbl();
    inv_tbl_t t;
    elem_t    d;
    elem_t    x;
    elem_t    e;
    for (int i = 0; i < OddCnt; i++) begin
      d = elem_t'(2 * i + 1);
      x = d;
      for (int k = 0; k < 3; k++) begin
        e = elem_t'(d * x);
        e = elem_t'(elem_t'(2) - e);
        x = elem_t'(x * e);
      end
      t[i] = x;
    end
    return t;
  endfunction

  localparam inv_tbl_t INV_TBL = build_inv_tbl();

endpackage

FILE: hw/rtl/mmi_if.sv
`timescale 1ns / 1ps

interface mmi_in_if import mmi_pkg::*; ();
  logic  valid;
  logic  ready;
  elem_t key_r0c0;
  elem_t key_r0c1;
  elem_t key_r0c2;
  elem_t key_r1c0;
  elem_t key_r1c1;
  elem_t key_r1c2;
  elem_t key_r2c0;
  elem_t key_r2c1;
  elem_t key_r2c2;

  modport source (
    output valid, key_r0c0, key_r0c1, key_r0c2, key_r1c0, key_r1c1, key_r1c2,
           key_r2c0, key_r2c1, key_r2c2,
    input  ready
  );
  modport sink (
    input  valid, key_r0c0, key_r0c1, key_r0c2, key_r1c0, key_r1c1, key_r1c2,
           key_r2c0, key_r2c1, key_r2c2,
    output ready
  );
endinterface

interface mmi_out_if import mmi_pkg::*; ();
  logic  valid;
  logic  ready;
  elem_t inv_r0c0;
  elem_t inv_r0c1;
  elem_t inv_r0c2;
  elem_t inv_r1c0;
  elem_t inv_r1c1;
  elem_t inv_r1c2;
  elem_t inv_r2c0;
  elem_t inv_r2c1;
  elem_t inv_r2c2;
  logic  invertible;

  modport source (
    output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2,
           inv_r2c0, inv_r2c1, inv_r2c2, invertible,
    input  ready
  );
  modport sink (
    input  valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2,
           inv_r2c0, inv_r2c1, inv_r2c2, invertible,
    output ready
  );
endinterface

FILE: hw/rtl/mmi_cofactor_lane.sv
`timescale 1ns / 1ps

module mmi_cofactor_lane import mmi_pkg::*; (
  input  elem_t p,
  input  elem_t s,
  input  elem_t q,
  input  elem_t r,
  input  logic  neg,
  output elem_t cof
);
  elem_t ps;
  elem_t qr;
  elem_t minor;

  // p*s - q*r, all wrapping mod 256
  assign ps    = elem_t'(p * s);
  assign qr    = elem_t'(q * r);
  assign minor = elem_t'(ps - qr);
  assign cof   = neg ? elem_t'(elem_t'(0) - minor) : minor;
endmodule

FILE: hw/rtl/mmi_mul_lane.sv
`timescale 1ns / 1ps

module mmi_mul_lane import mmi_pkg::*; (
  input  elem_t a,
  input  elem_t b,
  input  logic  en,
  output elem_t y
);
  logic [2*ElemW-1:0] full;

  assign full = a * b;
  assign y    = en ? full[ElemW-1:0] : '0;
endmodule

FILE: hw/rtl/mmi_det_merge.sv
`timescale 1ns / 1ps

module mmi_det_merge import mmi_pkg::*; (
  input  vec_t      prod,
  output det_info_t info
);
  elem_t det;

  assign det       = elem_t'(prod[0] + prod[1] + prod[2]);
  assign info.odd  = det[0];
  // even determinants never use dinv, the lanes force zero
  assign info.dinv = INV_TBL[det[ElemW-1:1]];
endmodule

FILE: hw/rtl/modular_matrix_inverse_3x3.sv
`timescale 1ns / 1ps

// 3x3 byte matrix inverse mod 256 (hill cipher key inverse). one key matrix
// per in_if transaction, one inverse per out_if transaction, in order. the
// block is a four stage pipeline and takes a new matrix every cycle unless
// out_if.ready is low with every stage full; a matrix moves through the
// stage valid bits v1_r, v2_r, v3_r and v4_r, and out_if.valid is v4_r.
// stage one runs nine cofactor lanes in parallel, stage two forms
// the three row-0 products, stage three merges them into the determinant and
// looks up its odd inverse in a 128 entry constant table, stage four runs
// nine scaling lanes. an even determinant gives invertible low and an all
// zero matrix. every stage has its own valid bit, so empty stages fill even
// while a finished result waits on out_if.ready.

module modular_matrix_inverse_3x3 import mmi_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  mmi_in_if.sink      in_if,
  mmi_out_if.source   out_if
);

  // stage valid bits and per stage advance enables
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  // key matrix as seen on the input transaction
  mat_t km;

  // stage payloads
  mat_t      adj_nxt;
  mat_t      adj1_r, adj2_r, adj3_r;
  vec_t      row0_r;
  vec_t      prod_nxt;
  vec_t      prod2_r;
  det_info_t info_nxt;
  det_info_t info3_r;
  mat_t      inv_nxt;
  mat_t      inv4_r;
  logic      invertible4_r;

  assign km[0][0] = in_if.key_r0c0;
  assign km[0][1] = in_if.key_r0c1;
  assign km[0][2] = in_if.key_r0c2;
  assign km[1][0] = in_if.key_r1c0;
  assign km[1][1] = in_if.key_r1c1;
  assign km[1][2] = in_if.key_r1c2;
  assign km[2][0] = in_if.key_r2c0;
  assign km[2][1] = in_if.key_r2c1;
  assign km[2][2] = in_if.key_r2c2;

  // a stage may load when it is empty or the one after it moves on
  assign rdy4 = !v4_r || out_if.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_if.ready = rdy1;

  // stage one: adjugate, the transpose of the cofactor matrix
  mmi_cofactor_lane u_cof00 (.p(km[1][1]), .s(km[2][2]), .q(km[1][2]), .r(km[2][1]),
                             .neg(1'b0), .cof(adj_nxt[0][0]));
  mmi_cofactor_lane u_cof01 (.p(km[0][1]), .s(km[2][2]), .q(km[0][2]), .r(km[2][1]),
                             .neg(1'b1), .cof(adj_nxt[0][1]));
  mmi_cofactor_lane u_cof02 (.p(km[0][1]), .s(km[1][2]), .q(km[0][2]), .r(km[1][1]),
                             .neg(1'b0), .cof(adj_nxt[0][2]));
  mmi_cofactor_lane u_cof10 (.p(km[1][0]), .s(km[2][2]), .q(km[1][2]), .r(km[2][0]),
                             .neg(1'b1), .cof(adj_nxt[1][0]));
  mmi_cofactor_lane u_cof11 (.p(km[0][0]), .s(km[2][2]), .q(km[0][2]), .r(km[2][0]),
                             .neg(1'b0), .cof(adj_nxt[1][1]));
  mmi_cofactor_lane u_cof12 (.p(km[0][0]), .s(km[1][2]), .q(km[0][2]), .r(km[1][0]),
                             .neg(1'b1), .cof(adj_nxt[1][2]));
  mmi_cofactor_lane u_cof20 (.p(km[1][0]), .s(km[2][1]), .q(km[1][1]), .r(km[2][0]),
                             .neg(1'b0), .cof(adj_nxt[2][0]));
  mmi_cofactor_lane u_cof21 (.p(km[0][0]), .s(km[2][1]), .q(km[0][1]), .r(km[2][0]),
                             .neg(1'b1), .cof(adj_nxt[2][1]));
  mmi_cofactor_lane u_cof22 (.p(km[0][0]), .s(km[1][1]), .q(km[0][1]), .r(km[1][0]),
                             .neg(1'b0), .cof(adj_nxt[2][2]));

  // stage two: expansion along row 0 against adjugate column 0
  genvar k;
  generate
    for (k = 0; k < DimN; k++) begin : g_det
      mmi_mul_lane u_dprod (
        .a  (row0_r[k]),
        .b  (adj1_r[k][0]),
        .en (1'b1),
        .y  (prod_nxt[k])
      );
    end
  endgenerate

  // stage three: determinant and its inverse
  mmi_det_merge u_merge (
    .prod (prod2_r),
    .info (info_nxt)
  );

  // stage four: scale every adjugate entry, zero when not invertible
  genvar i, j;
  generate
    for (i = 0; i < DimN; i++) begin : g_row
      for (j = 0; j < DimN; j++) begin : g_col
        mmi_mul_lane u_scale (
          .a  (adj3_r[i][j]),
          .b  (info3_r.dinv),
          .en (info3_r.odd),
          .y  (inv_nxt[i][j])
        );
      end
    end
  endgenerate

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_if.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // payload registers, loaded only when a transaction moves in
  always_ff @(posedge clk) begin
    if (rdy1 && in_if.valid) begin
      adj1_r <= adj_nxt;
      row0_r <= km[0];
    end
    if (rdy2 && v1_r) begin
      prod2_r <= prod_nxt;
      adj2_r  <= adj1_r;
    end
    if (rdy3 && v2_r) begin
      info3_r <= info_nxt;
      adj3_r  <= adj2_r;
    end
    if (rdy4 && v3_r) begin
      inv4_r        <= inv_nxt;
      invertible4_r <= info3_r.odd;
    end
  end

  // result transaction
  assign out_if.valid      = v4_r;
  assign out_if.inv_r0c0   = inv4_r[0][0];
  assign out_if.inv_r0c1   = inv4_r[0][1];
  assign out_if.inv_r0c2   = inv4_r[0][2];
  assign out_if.inv_r1c0   = inv4_r[1][0];
  assign out_if.inv_r1c1   = inv4_r[1][1];
  assign out_if.inv_r1c2   = inv4_r[1][2];
  assign out_if.inv_r2c0   = inv4_r[2][0];
  assign out_if.inv_r2c1   = inv4_r[2][1];
  assign out_if.inv_r2c2   = inv4_r[2][2];
  assign out_if.invertible = invertible4_r;

endmodule

FILE: hw/rtl/mmi_checker.sv
`timescale 1ns / 1ps

module mmi_checker import mmi_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input elem_t inv_r0c0,
  input elem_t inv_r0c1,
  input elem_t inv_r0c2,
  input elem_t inv_r1c0,
  input elem_t inv_r1c1,
  input elem_t inv_r1c2,
  input elem_t inv_r2c0,
  input elem_t inv_r2c1,
  input elem_t inv_r2c2,
  input logic  invertible
);
  logic in_acc;
  logic any_nonzero;

  assign in_acc      = in_valid && in_ready;
  assign any_nonzero = (inv_r0c0 != '0) || (inv_r0c1 != '0) || (inv_r0c2 != '0) ||
                       (inv_r1c0 != '0) || (inv_r1c1 != '0) || (inv_r1c2 != '0) ||
                       (inv_r2c0 != '0) || (inv_r2c1 != '0) || (inv_r2c2 != '0);

  // a stalled result keeps valid, invertible and inv_r1c1 stable
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(invertible) && $stable(inv_r1c1))
    else $error("stalled result changed");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // singular key gives an all zero matrix
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !invertible |-> !any_nonzero)
    else $error("non-zero entries on singular key");

  // with the sink always ready an accepted transaction comes out once it has passed the pipeline
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && out_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after pipeline latency");
endmodule

bind modular_matrix_inverse_3x3 mmi_checker u_mmi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .inv_r0c0   (out_if.inv_r0c0),
  .inv_r0c1   (out_if.inv_r0c1),
  .inv_r0c2   (out_if.inv_r0c2),
  .inv_r1c0   (out_if.inv_r1c0),
  .inv_r1c1   (out_if.inv_r1c1),
  .inv_r1c2   (out_if.inv_r1c2),
  .inv_r2c0   (out_if.inv_r2c0),
  .inv_r2c1   (out_if.inv_r2c1),
  .inv_r2c2   (out_if.inv_r2c2),
  .invertible (out_if.invertible)
);

FILE: bench/testbench.sv
`timescale 1ns / 1ps

// bench for the 3x3 key matrix inverse mod 256: a queue of key matrices feeds
// a clocked driver, a clocked monitor checks every inverse against a local
// predictor, and the idle rates of both sides change over three profiles

module testbench;
  import mmi_pkg::*;

  // cycles with no transaction on either side before the run is declared hung
  localparam int StallLimit = 2000;
  // quiet cycles after the last inverse, well past the four stage pipeline
  localparam int DrainCycles = 16;
  // past this many reports, mismatches are only counted
  localparam int ReportCap = 200;

  typedef struct packed {
    mat_t inv;
    logic invertible;
  } inv_result_t;

  logic clk;
  logic rst_n;

  mmi_in_if  in_ch ();
  mmi_out_if out_ch ();

  modular_matrix_inverse_3x3 u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // key matrices not yet offered, inverses not yet seen
  mat_t        key_q[$];
  inv_result_t inv_exp_q[$];

  mat_t        held_key;
  int          tx_idle_pct;
  int          rx_idle_pct;
  logic        hold_off;
  int          idle_cycles;
  int          mismatches;
  int          results_seen;
  int          invertible_seen;
  inv_result_t mon_act;
  inv_result_t mon_exp;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor: adjugate and determinant with 8 bit wrap, so negative
  // cofactors land on their residue; the determinant inverse is found by
  // scanning the odd bytes
  // ---------------------------------------------------------------------------
  function automatic inv_result_t invert_key(mat_t k);
    mat_t        adj;
    elem_t       det;
    elem_t       dinv;
    elem_t       prod;
    inv_result_t res;
    adj[0][0] = k[1][1] * k[2][2] - k[1][2] * k[2][1];
    adj[0][1] = k[0][2] * k[2][1] - k[0][1] * k[2][2];
    adj[0][2] = k[0][1] * k[1][2] - k[0][2] * k[1][1];
    adj[1][0] = k[1][2] * k[2][0] - k[1][0] * k[2][2];
    adj[1][1] = k[0][0] * k[2][2] - k[0][2] * k[2][0];
    adj[1][2] = k[0][2] * k[1][0] - k[0][0] * k[1][2];
    adj[2][0] = k[1][0] * k[2][1] - k[1][1] * k[2][0];
    adj[2][1] = k[0][1] * k[2][0] - k[0][0] * k[2][1];
    adj[2][2] = k[0][0] * k[1][1] - k[0][1] * k[1][0];
    // expansion along row 0 against column 0 of the adjugate
    det = k[0][0] * adj[0][0] + k[0][1] * adj[1][0] + k[0][2] * adj[2][0];
    dinv = '0;
    for (int x = 1; x < 256; x += 2) begin
      prod = det * elem_t'(x);
      if (prod == elem_t'(1)) dinv = elem_t'(x);
    end
    res.invertible = det[0];
    for (int r = 0; r < DimN; r++) begin
      for (int c = 0; c < DimN; c++) begin
        // an even determinant has no inverse: all entries zero
        res.inv[r][c] = det[0] ? elem_t'(adj[r][c] * dinv) : elem_t'(0);
      end
    end
    return res;
  endfunction

  function automatic mat_t key_of(elem_t a, elem_t b, elem_t c, elem_t d, elem_t e,
                                  elem_t f, elem_t g, elem_t h, elem_t i);
    mat_t m;
    m[0][0] = a; m[0][1] = b; m[0][2] = c;
    m[1][0] = d; m[1][1] = e; m[1][2] = f;
    m[2][0] = g; m[2][1] = h; m[2][2] = i;
    return m;
  endfunction

  // mix of fully random keys, keys built from corner bytes, and triangular
  // keys with an odd diagonal, which are always invertible; a row swap on
  // the latter flips the sign of the determinant
  task automatic add_random_keys(int n);
    mat_t  m;
    vec_t  row_tmp;
    int    mode;
    for (int k = 0; k < n; k++) begin
      mode = $urandom_range(99);
      for (int r = 0; r < DimN; r++) begin
        for (int c = 0; c < DimN; c++) begin
          if (mode < 60) begin
            m[r][c] = elem_t'($urandom);
          end else if (mode < 80) begin
            case ($urandom_range(4))
              0: m[r][c] = 8'h00;
              1: m[r][c] = 8'hff;
              2: m[r][c] = 8'h01;
              3: m[r][c] = 8'h80;
              default: m[r][c] = elem_t'($urandom);
            endcase
          end else begin
            if (c == r) m[r][c] = elem_t'($urandom) | 8'h01;
            else if (c > r) m[r][c] = elem_t'($urandom);
            else m[r][c] = 8'h00;
          end
        end
      end
      if (mode >= 80 && $urandom_range(1) == 1) begin
        row_tmp = m[0];
        m[0] = m[2];
        m[2] = row_tmp;
      end
      key_q.push_back(m);
    end
  endtask

  // with_queue low: only wait for the pipeline and the expectations to empty
  task automatic wait_drained(bit with_queue);
    @(posedge clk);
    while ((with_queue && key_q.size() != 0) || in_ch.valid || inv_exp_q.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // driver: a new key goes out only when the slot is free, so valid never
  // drops while a transaction is pending
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        inv_exp_q.push_back(invert_key(held_key));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (!hold_off && key_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          held_key = key_q.pop_front();
          in_ch.key_r0c0 <= held_key[0][0];
          in_ch.key_r0c1 <= held_key[0][1];
          in_ch.key_r0c2 <= held_key[0][2];
          in_ch.key_r1c0 <= held_key[1][0];
          in_ch.key_r1c1 <= held_key[1][1];
          in_ch.key_r1c2 <= held_key[1][2];
          in_ch.key_r2c0 <= held_key[2][0];
          in_ch.key_r2c1 <= held_key[2][1];
          in_ch.key_r2c2 <= held_key[2][2];
          in_ch.valid    <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: each inverse transaction against the oldest expectation, then a
  // fresh random ready for the next cycle
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        mon_act.inv[0][0]  = out_ch.inv_r0c0;
        mon_act.inv[0][1]  = out_ch.inv_r0c1;
        mon_act.inv[0][2]  = out_ch.inv_r0c2;
        mon_act.inv[1][0]  = out_ch.inv_r1c0;
        mon_act.inv[1][1]  = out_ch.inv_r1c1;
        mon_act.inv[1][2]  = out_ch.inv_r1c2;
        mon_act.inv[2][0]  = out_ch.inv_r2c0;
        mon_act.inv[2][1]  = out_ch.inv_r2c1;
        mon_act.inv[2][2]  = out_ch.inv_r2c2;
        mon_act.invertible = out_ch.invertible;
        if (inv_exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportCap) $error("inverse transaction with none expected");
        end else begin
          mon_exp = inv_exp_q.pop_front();
          results_seen++;
          if (mon_exp.invertible) invertible_seen++;
          if (mon_act.invertible !== mon_exp.invertible) begin
            mismatches++;
            if (mismatches <= ReportCap)
              $error("invertible: expected %0b, actual %0b",
                     mon_exp.invertible, mon_act.invertible);
          end
          for (int r = 0; r < DimN; r++) begin
            for (int c = 0; c < DimN; c++) begin
              if (mon_act.inv[r][c] !== mon_exp.inv[r][c]) begin
                mismatches++;
                if (mismatches <= ReportCap)
                  $error("inv_r%0dc%0d: expected 0x%02h, actual 0x%02h",
                         r, c, mon_exp.inv[r][c], mon_act.inv[r][c]);
              end
            end
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog: any transaction on either side restarts the count
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= StallLimit);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus and phase control
  // ---------------------------------------------------------------------------
  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.key_r0c0  = '0;
    in_ch.key_r0c1  = '0;
    in_ch.key_r0c2  = '0;
    in_ch.key_r1c0  = '0;
    in_ch.key_r1c1  = '0;
    in_ch.key_r1c2  = '0;
    in_ch.key_r2c0  = '0;
    in_ch.key_r2c1  = '0;
    in_ch.key_r2c2  = '0;
    out_ch.ready    = 1'b0;
    held_key        = '0;
    hold_off        = 1'b0;
    tx_idle_pct     = 38;
    rx_idle_pct     = 56;
    idle_cycles     = 0;
    mismatches      = 0;
    results_seen    = 0;
    invertible_seen = 0;

    // directed keys: zero and all-ones matrices, identity and its negation,
    // permutations with determinant -1, an even nonzero determinant, a
    // textbook hill key, triangular keys full of 0xff, checkerboard bytes,
    // a bit-7-only diagonal and a singular matrix with nonzero rows
    key_q.push_back(key_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    key_q.push_back(key_of(8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01));
    key_q.push_back(key_of(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    key_q.push_back(key_of(8'hff, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 8'hff));
    key_q.push_back(key_of(8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01));
    key_q.push_back(key_of(8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00));
    key_q.push_back(key_of(8'h02, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01));
    key_q.push_back(key_of(8'd6, 8'd24, 8'd1, 8'd13, 8'd16, 8'd10, 8'd20, 8'd17, 8'd15));
    key_q.push_back(key_of(8'h01, 8'hff, 8'hff, 8'h00, 8'h01, 8'hff, 8'h00, 8'h00, 8'h01));
    key_q.push_back(key_of(8'hff, 8'h00, 8'h00, 8'hff, 8'hff, 8'h00, 8'hff, 8'hff, 8'hff));
    key_q.push_back(key_of(8'h55, 8'haa, 8'haa, 8'haa, 8'h55, 8'haa, 8'haa, 8'haa, 8'h55));
    key_q.push_back(key_of(8'haa, 8'h55, 8'h55, 8'h55, 8'haa, 8'h55, 8'h55, 8'h55, 8'haa));
    key_q.push_back(key_of(8'h80, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01));
    key_q.push_back(key_of(8'd3, 8'd0, 8'd0, 8'd0, 8'd5, 8'd0, 8'd0, 8'd0, 8'd7));
    key_q.push_back(key_of(8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd10));
    key_q.push_back(key_of(8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9));
    key_q.push_back(key_of(8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'hff));
    add_random_keys(300);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // phase one: sender idles 38%, receiver 56%; partway through, the
    // sender holds off until the pipeline has emptied
    @(posedge clk);
    while (key_q.size() > 150) @(posedge clk);
    hold_off <= 1'b1;
    wait_drained(1'b0);
    hold_off <= 1'b0;
    wait_drained(1'b1);

    // phase two: idle rates swapped
    tx_idle_pct <= 56;
    rx_idle_pct <= 38;
    add_random_keys(320);
    wait_drained(1'b1);

    // phase three: full rate on both sides
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    add_random_keys(320);
    wait_drained(1'b1);

    // nothing else may come out of the pipeline
    repeat (DrainCycles) @(posedge clk);

    $display("checked %0d key matrices (%0d invertible, %0d singular)",
             results_seen, invertible_seen, results_seen - invertible_seen);
    $display("idle profiles: sender-heavy, receiver-heavy, none; one full hold-off");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
